/* src/tcavr_pkg.sv */
// ----------------------------------------------------------------------------
// tcavr_pkg - thermocouple average and ramp, shared definitions
// Field widths, scaling constants and the reciprocal used for the ramp divide.
// ----------------------------------------------------------------------------
package tcavr_pkg;

    // converter frame layout
    localparam int FRAME_W  = 16;
    localparam int TEMP_LSB = 3;
    localparam int TEMP_W   = 13;

    // result widths
    localparam int MEAN_W = 17;
    localparam int RAMP_W = 18;

    // quarter degrees to 1/64 degree: multiply by 16
    localparam int SCALE_SH = 4;

    // default depths
    localparam int AVG_DEPTH_DEF     = 8;
    localparam int HISTORY_DEPTH_DEF = 16;

    // ramp window and saturation
    localparam int WINDOW_MS  = 2000;
    localparam int MS_PER_S   = 1000;
    localparam int RAMP_LIMIT = 131071;

    // |mean difference| * 1000 < 2^27
    localparam int PROD_W = 27;

    // exact divide by WINDOW_MS for any dividend below 2^PROD_W:
    // q = (p * ceil(2^(PROD_W+L) / W)) >> (PROD_W+L), L = ceil(log2 W)
    localparam int WIN_LOG  = $clog2(WINDOW_MS);
    localparam int RECIP_SH = PROD_W + WIN_LOG;
    localparam int RECIP_W  = PROD_W + 1;
    localparam int WIDE_W   = PROD_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SH) + 64'(WINDOW_MS) - 64'd1) / 64'(WINDOW_MS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef logic [TEMP_W-1:0] temp_t;
    typedef logic [MEAN_W-1:0] mean_t;
    typedef logic signed [RAMP_W-1:0] ramp_t;

endpackage

/* src/thermocouple_average_and_ramp.sv */
// ----------------------------------------------------------------------------
// thermocouple_average_and_ramp - moving average and window ramp
// Converter frame in, mean temperature and rate of change out.
// ----------------------------------------------------------------------------
// Takes one converter frame beat per clock while in_ready is high and returns
// one result beat per frame, in order, via stages 1 to 4 and the output
// register. The temperature (frame bits 15..3, quarter degrees) replaces the
// oldest entry of an AVG_DEPTH sample RAM, a running sum is kept and the mean
// is given in 1/64 degree. Each mean goes into a HISTORY_DEPTH history RAM and
// the ramp is (mean - mean HISTORY_DEPTH samples ago) * 1000 / WINDOW_MS,
// truncated toward zero and saturated to +-131071. The first frame after reset
// gives a ramp of 0 and stands in for the whole history. Throughput is one
// frame per cycle while the output side is not stalled; the running sum is
// updated from the sample RAM read in stage 1. The sample RAM is read and
// written in the accept cycle, and a history write in the same cycle as the
// read of that entry is forwarded. The sample ring reads as zero until written
// (one valid bit per entry), so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module thermocouple_average_and_ramp
    import tcavr_pkg::*;
#(
    parameter int AVG_DEPTH     = AVG_DEPTH_DEF,
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FRAME_W-1:0] frame_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MEAN_W-1:0]  mean_temp,
    output logic [RAMP_W-1:0]  ramp_rate
);

    // the user must keep AVG_DEPTH a power of two (not checked here), so the mean is a shift
    localparam int AVG_LOG = $clog2(AVG_DEPTH);
    localparam int AVG_AW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W   = TEMP_W + AVG_LOG;
    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [AVG_AW-1:0]  AVG_LAST  = AVG_AW'(AVG_DEPTH - 1);
    localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HISTORY_DEPTH - 1);

    // ---------------------------------------------------------------- flow
    logic load_out;
    logic load_s4;
    logic load_s3;
    logic load_s2;
    logic load_s1;
    logic accept;
    logic fire1;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;

    // each stage loads when empty or when its beat moves on
    assign load_out = !out_valid_reg || out_ready;
    assign load_s4  = !s4_valid_reg || load_out;
    assign load_s3  = !s3_valid_reg || load_s4;
    assign load_s2  = !s2_valid_reg || load_s3;
    assign load_s1  = !s1_valid_reg || load_s2;
    assign in_ready = load_s1;
    assign accept   = in_valid && load_s1;
    assign fire1    = s1_valid_reg && load_s2;

    // ---------------------------------------------------------------- accept
    temp_t                temp;
    logic [AVG_AW-1:0]    samp_slot_reg;
    logic [AVG_AW-1:0]    samp_slot_next;
    logic [AVG_DEPTH-1:0] samp_vld_reg;
    logic [HIST_AW-1:0]   hist_rd_slot_reg;
    logic [HIST_AW-1:0]   hist_rd_slot_next;
    temp_t                samp_rd;
    mean_t                hist_rd;

    assign temp = frame_word[TEMP_LSB +: TEMP_W];

    assign samp_slot_next    = (samp_slot_reg == AVG_LAST) ? '0 : samp_slot_reg + 1'b1;
    assign hist_rd_slot_next = (hist_rd_slot_reg == HIST_LAST) ? '0
                                                               : hist_rd_slot_reg + 1'b1;

    // sample ring: old entry read and new one written in the accept cycle
    tcavr_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (AVG_DEPTH)
    ) u_samp_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (samp_slot_reg),
        .wr_data (temp),
        .rd_en   (accept),
        .rd_addr (samp_slot_reg),
        .rd_data (samp_rd)
    );

    // ---------------------------------------------------------------- stage 1
    temp_t              s1_temp_reg;
    logic               s1_old_vld_reg;
    logic [HIST_AW-1:0] s1_hslot_reg;
    logic               s1_fwd_hit_reg;
    mean_t              s1_fwd_data_reg;

    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    temp_t                     samp_old;
    logic [SUM_W+SCALE_SH-1:0] mean_wide;
    mean_t                     s1_mean;
    mean_t                     hist_old;
    logic                      primed_reg;
    logic                      lap_done_reg;
    mean_t                     first_mean_reg;
    logic                      fwd_hit;

    assign samp_old  = s1_old_vld_reg ? samp_rd : '0;
    assign sum_next  = sum_reg - SUM_W'(samp_old) + SUM_W'(s1_temp_reg);
    assign mean_wide = {sum_next, {SCALE_SH{1'b0}}} >> AVG_LOG;
    assign s1_mean   = mean_wide[MEAN_W-1:0];

    // history not yet written since the first beat holds the first mean
    assign hist_old = !lap_done_reg   ? first_mean_reg :
                      s1_fwd_hit_reg ? s1_fwd_data_reg : hist_rd;

    // write in this cycle to the entry the new beat reads
    assign fwd_hit = fire1 && (s1_hslot_reg == hist_rd_slot_reg);

    tcavr_ram #(
        .WIDTH (MEAN_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (fire1),
        .wr_addr (s1_hslot_reg),
        .wr_data (s1_mean),
        .rd_en   (accept),
        .rd_addr (hist_rd_slot_reg),
        .rd_data (hist_rd)
    );

    // ---------------------------------------------------------------- stage 2
    mean_t             s2_mean_reg;
    mean_t             s2_old_reg;
    logic              s2_first_reg;
    logic              s2_neg;
    mean_t             s2_mag;
    logic [PROD_W-1:0] s2_prod;

    assign s2_neg  = s2_mean_reg < s2_old_reg;
    assign s2_mag  = s2_neg ? (s2_old_reg - s2_mean_reg) : (s2_mean_reg - s2_old_reg);
    assign s2_prod = PROD_W'(s2_mag) * PROD_W'(MS_PER_S);

    // ---------------------------------------------------------------- stage 3
    mean_t             s3_mean_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic              s3_neg_reg;
    logic              s3_first_reg;
    logic [WIDE_W-1:0] s3_wide;

    // divide by WINDOW_MS as a multiply by its reciprocal
    assign s3_wide = WIDE_W'(s3_prod_reg) * WIDE_W'(RECIP);

    // ---------------------------------------------------------------- stage 4
    mean_t              s4_mean_reg;
    logic [WIDE_W-1:0]  s4_wide_reg;
    logic               s4_neg_reg;
    logic               s4_first_reg;
    logic [WIDE_W-1:0]  quot_wide;
    logic [PROD_W-1:0]  quot;
    logic [MEAN_W-1:0]  quot_sat;
    ramp_t              ramp_next;

    assign quot_wide = s4_wide_reg >> RECIP_SH;
    assign quot      = quot_wide[PROD_W-1:0];
    assign quot_sat  = (quot > PROD_W'(RAMP_LIMIT)) ? MEAN_W'(RAMP_LIMIT)
                                                    : quot[MEAN_W-1:0];
    assign ramp_next = s4_first_reg ? '0 :
                       s4_neg_reg   ? -RAMP_W'(quot_sat) : RAMP_W'(quot_sat);

    // ---------------------------------------------------------------- output
    mean_t mean_reg;
    ramp_t ramp_reg;

    assign out_valid = out_valid_reg;
    assign mean_temp = mean_reg;
    assign ramp_rate = ramp_reg;

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            samp_slot_reg    <= '0;
            samp_vld_reg     <= '0;
            hist_rd_slot_reg <= '0;
            sum_reg          <= '0;
            primed_reg       <= 1'b0;
            lap_done_reg     <= 1'b0;
        end
        else
        begin
            if (load_s1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (load_s2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (load_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (load_s4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
            if (accept)
            begin
                samp_slot_reg               <= samp_slot_next;
                samp_vld_reg[samp_slot_reg] <= 1'b1;
                hist_rd_slot_reg            <= hist_rd_slot_next;
            end
            if (fire1)
            begin
                sum_reg    <= sum_next;
                primed_reg <= 1'b1;
                if (s1_hslot_reg == HIST_LAST)
                begin
                    lap_done_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_temp_reg     <= temp;
            s1_old_vld_reg  <= samp_vld_reg[samp_slot_reg];
            s1_hslot_reg    <= hist_rd_slot_reg;
            s1_fwd_hit_reg  <= fwd_hit;
            s1_fwd_data_reg <= s1_mean;
        end
        if (fire1 && !primed_reg)
        begin
            first_mean_reg <= s1_mean;
        end
        if (load_s2)
        begin
            s2_mean_reg  <= s1_mean;
            s2_old_reg   <= hist_old;
            s2_first_reg <= !primed_reg;
        end
        if (load_s3)
        begin
            s3_mean_reg  <= s2_mean_reg;
            s3_prod_reg  <= s2_prod;
            s3_neg_reg   <= s2_neg;
            s3_first_reg <= s2_first_reg;
        end
        if (load_s4)
        begin
            s4_mean_reg  <= s3_mean_reg;
            s4_wide_reg  <= s3_wide;
            s4_neg_reg   <= s3_neg_reg;
            s4_first_reg <= s3_first_reg;
        end
        if (load_out)
        begin
            mean_reg <= s4_mean_reg;
            ramp_reg <= ramp_next;
        end
    end

`ifndef SYNTHESIS
    // an accepted beat lands in stage 1
    a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat missing from stage 1");

    // input stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                       && s4_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    // the first beat through stage 1 carries the zero-ramp mark
    a_first_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (fire1 && !primed_reg) |=> (s2_valid_reg && s2_first_reg && primed_reg))
        else $error("first beat not marked");

    // history lap cannot complete before the first beat
    a_lap_after_prime: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> !lap_done_reg)
        else $error("history lap done before first beat");

    // ramp stays inside the saturation limits
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ramp_reg != ramp_t'(-RAMP_LIMIT - 1)))
        else $error("ramp outside saturation range");
`endif

endmodule

/* src/tcavr_ram.sv */
// ----------------------------------------------------------------------------
// tcavr_ram - generic single-clock RAM
// One write port, one read port with registered read data (read-first).
// ----------------------------------------------------------------------------
module tcavr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
